// ===== design/led_frame_power_limit_dither_core_assert.svh =====
// ----------------------------------------------------------------------------
// led frame power limit dither core: assertion macros
// concurrent checks that compile away under synthesis
// ----------------------------------------------------------------------------
`ifndef LED_FRAME_POWER_LIMIT_DITHER_CORE_ASSERT_SVH
`define LED_FRAME_POWER_LIMIT_DITHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LFPLD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfpld assertion failed");

// next-cycle implication
`define LFPLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfpld assertion failed");

`else

`define LFPLD_ASSERT_SAME(label, clk, rst, ante, cons)
`define LFPLD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/lfpld_pkg.sv =====
// ----------------------------------------------------------------------------
// lfpld_pkg
// shared types and constants of the led frame power limit dither core
// ----------------------------------------------------------------------------
package lfpld_pkg;

  localparam int DEF_MAX_PIXELS = 64;

  // idle draw of one pixel in mW
  localparam int IDLE_MW_PER_PIXEL = 5;

  // per-channel power weights, applied before the >> 8
  localparam logic [6:0] COEF_RED   = 7'd80;
  localparam logic [6:0] COEF_GREEN = 7'd55;
  localparam logic [6:0] COEF_BLUE  = 7'd75;

  localparam int BUDGET_W = 16;
  localparam int DIV_NUM_W = 24;
  localparam int DIV_STEPS = 8;

  localparam logic [15:0] RST_BUDGET     = 16'd10000;
  localparam logic [7:0]  RST_CORR_RED   = 8'hFF;
  localparam logic [7:0]  RST_CORR_GREEN = 8'hB0;
  localparam logic [7:0]  RST_CORR_BLUE  = 8'hF0;

  typedef enum logic [1:0] {
    REG_BUDGET      = 2'd0,
    REG_CORR_RED    = 2'd1,
    REG_CORR_GREEN  = 2'd2,
    REG_CORR_BLUE   = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_LOAD,
    ST_PROD,
    ST_EST,
    ST_REQ,
    ST_CMP,
    ST_DIV,
    ST_GAIN,
    ST_EMIT,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic load;
    logic prod;
    logic est;
    logic req;
    logic div_start;
    logic take_target;
    logic take_quot;
    logic gain;
    logic emit;
    logic sweep;
    logic frame_done;
  } cmd_t;

  typedef struct packed {
    logic over_budget;
    logic div_done;
    logic last_issue;
    logic tail_clear;
    logic sweep_last;
  } status_t;

endpackage

// ===== design/lfpld_div.sv =====
// ----------------------------------------------------------------------------
// lfpld_div
// restoring divider, one quotient bit per cycle, 8-bit quotient
// ----------------------------------------------------------------------------
module lfpld_div import lfpld_pkg::*; #(
  parameter int DEN_W = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DEN_W-1:0]     den,
  output logic [7:0]           quotient,
  output logic                 done
);

  localparam int RW    = (DEN_W > 16) ? DEN_W : 16;
  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [RW-1:0]    rem;
  logic [7:0]       lo;
  logic [CNT_W-1:0] cnt;
  logic             active;
  logic [RW:0]      shifted;
  logic [RW:0]      den_ext;
  logic             ge;
  logic [RW:0]      diff;

  // quotient is known to fit 8 bits, so the top of num is already below den
  assign shifted = {rem, lo[7]};
  assign den_ext = (RW + 1)'(den);
  assign ge      = shifted >= den_ext;
  assign diff    = shifted - den_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      if (start) begin
        rem      <= RW'(num[DIV_NUM_W-1:8]);
        lo       <= num[7:0];
        quotient <= '0;
        cnt      <= '0;
        active   <= 1'b1;
        done     <= 1'b0;
      end else if (active) begin
        rem      <= ge ? diff[RW-1:0] : shifted[RW-1:0];
        quotient <= {quotient[6:0], ge};
        lo       <= {lo[6:0], 1'b0};
        cnt      <= cnt + 1'b1;
        done     <= cnt == CNT_W'(DIV_STEPS - 1);
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          active <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

// ===== design/lfpld_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfpld_ctrl
// frame sequencer: load, power estimate, limit, emit, residual clear
// ----------------------------------------------------------------------------
module lfpld_ctrl import lfpld_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    frame_end,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        busy     = 1'b0;
        cmd.load = start;
        if (start && frame_end) begin
          state_next = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd.prod   = 1'b1;
        state_next = ST_EST;
      end
      ST_EST: begin
        cmd.est    = 1'b1;
        state_next = ST_REQ;
      end
      ST_REQ: begin
        cmd.req    = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (status.over_budget) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          cmd.take_target = 1'b1;
          state_next      = ST_GAIN;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.take_quot = 1'b1;
          state_next    = ST_GAIN;
        end
      end
      ST_GAIN: begin
        cmd.gain   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.frame_done = 1'b1;
        state_next     = status.tail_clear ? ST_SWEEP : ST_LOAD;
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== design/lfpld_dp.sv =====
// ----------------------------------------------------------------------------
// lfpld_dp
// pixel and residual stores, channel sums, power math and dither pipeline
// ----------------------------------------------------------------------------
module lfpld_dp import lfpld_pkg::*; #(
  parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        frame_end,
  input  logic [7:0]  brightness,
  input  logic        clear_residuals,
  input  logic        write_en,
  input  logic [1:0]  write_index,
  input  logic [15:0] write_data,
  output logic        strobe,
  output logic [5:0]  pixel_index,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [7:0]  out_blue,
  output logic        last_pixel
);

  localparam int CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int SUM_W = $clog2(255 * MAX_PIXELS + 1);
  localparam int PRD_W = SUM_W + 7;
  localparam int IDL_W = CNT_W + 8;
  localparam int EST_W = ((SUM_W > IDL_W) ? SUM_W : IDL_W) + 2;
  localparam int CMP_W = (EST_W > BUDGET_W) ? EST_W : BUDGET_W;

  function automatic logic [15:0] scale8(input logic [7:0] a, input logic [7:0] b);
    return 16'(a) * (16'(b) + 16'd1);
  endfunction

  // configuration
  logic [15:0] budget;
  logic [7:0]  corr_r;
  logic [7:0]  corr_g;
  logic [7:0]  corr_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= RST_BUDGET;
      corr_r <= RST_CORR_RED;
      corr_g <= RST_CORR_GREEN;
      corr_b <= RST_CORR_BLUE;
    end else if (write_en) begin
      unique case (reg_index_t'(write_index))
        REG_BUDGET:     budget <= write_data;
        REG_CORR_RED:   corr_r <= write_data[7:0];
        REG_CORR_GREEN: corr_g <= write_data[7:0];
        REG_CORR_BLUE:  corr_b <= write_data[7:0];
        default: ;
      endcase
    end
  end

  // frame load
  logic [23:0]      pix_mem [MAX_PIXELS];
  logic [23:0]      res_mem [MAX_PIXELS];
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_g;
  logic [SUM_W-1:0] sum_b;
  logic [CNT_W-1:0] count;
  logic [7:0]       target;
  logic             clr_flag;
  logic             full;

  assign full = count == CNT_W'(MAX_PIXELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
      count <= '0;
    end else if (cmd.frame_done) begin
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
      count <= '0;
    end else if (cmd.load && !full) begin
      sum_r <= sum_r + SUM_W'(red);
      sum_g <= sum_g + SUM_W'(green);
      sum_b <= sum_b + SUM_W'(blue);
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      pix_mem[count[AW-1:0]] <= {red, green, blue};
    end
    if (cmd.load && frame_end) begin
      target   <= brightness;
      clr_flag <= clear_residuals;
    end
  end

  // power estimate and limit
  logic [PRD_W-1:0]     prd_r;
  logic [PRD_W-1:0]     prd_g;
  logic [PRD_W-1:0]     prd_b;
  logic [IDL_W-1:0]     prd_idle;
  logic [EST_W-1:0]     est;
  logic [EST_W+7:0]     req_full;
  logic [EST_W-1:0]     requested;
  logic [DIV_NUM_W-1:0] div_num;
  logic [7:0]           div_quot;
  logic                 div_done;
  logic [7:0]           level;

  assign requested = req_full[EST_W+7:8];
  assign div_num   = DIV_NUM_W'(target) * DIV_NUM_W'(budget);

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      prd_r    <= PRD_W'(sum_r) * PRD_W'(COEF_RED);
      prd_g    <= PRD_W'(sum_g) * PRD_W'(COEF_GREEN);
      prd_b    <= PRD_W'(sum_b) * PRD_W'(COEF_BLUE);
      prd_idle <= IDL_W'(count) * IDL_W'(IDLE_MW_PER_PIXEL);
    end
    if (cmd.est) begin
      est <= EST_W'(prd_r >> 8) + EST_W'(prd_g >> 8) + EST_W'(prd_b >> 8)
           + EST_W'(prd_idle);
    end
    if (cmd.req) begin
      req_full <= (EST_W + 8)'(est) * (EST_W + 8)'(target);
    end
    if (cmd.take_target) begin
      level <= target;
    end else if (cmd.take_quot) begin
      level <= div_quot;
    end
  end

  lfpld_div #(
    .DEN_W (EST_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num      (div_num),
    .den      (requested),
    .quotient (div_quot),
    .done     (div_done)
  );

  // channel gains folded with the brightness
  logic [7:0]  gain_r;
  logic [7:0]  gain_g;
  logic [7:0]  gain_b;
  logic [15:0] gprod_r;
  logic [15:0] gprod_g;
  logic [15:0] gprod_b;

  assign gprod_r = scale8(corr_r, level);
  assign gprod_g = scale8(corr_g, level);
  assign gprod_b = scale8(corr_b, level);

  always_ff @(posedge clk) begin
    if (cmd.gain) begin
      gain_r <= gprod_r[15:8];
      gain_g <= gprod_g[15:8];
      gain_b <= gprod_b[15:8];
    end
  end

  // emit pipeline: read stage, then dither math into the output register
  logic [CNT_W-1:0] rd_ptr;
  logic [23:0]      pix_q;
  logic [23:0]      res_q;
  logic             s1_valid;
  logic [CNT_W-1:0] s1_ptr;
  logic             s1_last;
  logic [23:0]      res_eff;
  logic [15:0]      v_r;
  logic [15:0]      v_g;
  logic [15:0]      v_b;
  logic             res_we;
  logic [AW-1:0]    res_wa;
  logic [23:0]      res_wd;
  logic [CNT_W+5:0] idx_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
    end else if (cmd.gain) begin
      rd_ptr <= '0;
    end else if (cmd.emit || cmd.sweep) begin
      rd_ptr <= rd_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pix_q  <= pix_mem[rd_ptr[AW-1:0]];
      res_q  <= res_mem[rd_ptr[AW-1:0]];
      s1_ptr <= rd_ptr;
      s1_last <= rd_ptr == count - CNT_W'(1);
    end
  end

  // a clearing frame starts its residuals from zero
  assign res_eff = clr_flag ? '0 : res_q;
  assign v_r = scale8(pix_q[23:16], gain_r) + 16'(res_eff[23:16]);
  assign v_g = scale8(pix_q[15:8],  gain_g) + 16'(res_eff[15:8]);
  assign v_b = scale8(pix_q[7:0],   gain_b) + 16'(res_eff[7:0]);

  assign res_we = s1_valid || cmd.sweep;
  assign res_wa = cmd.sweep ? rd_ptr[AW-1:0] : s1_ptr[AW-1:0];
  assign res_wd = cmd.sweep ? '0 : {v_r[7:0], v_g[7:0], v_b[7:0]};

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[res_wa] <= res_wd;
    end
  end

  assign idx_ext = (CNT_W + 6)'(s1_ptr);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      s1_valid <= cmd.emit;
      strobe   <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      pixel_index <= idx_ext[5:0];
      out_green   <= v_g[15:8];
      out_red     <= v_r[15:8];
      out_blue    <= v_b[15:8];
      last_pixel  <= s1_last;
    end
  end

  // status back to the sequencer
  always_comb begin
    status.over_budget = (requested != '0) && (CMP_W'(requested) > CMP_W'(budget));
    status.div_done    = div_done;
    status.last_issue  = rd_ptr == count - CNT_W'(1);
    status.tail_clear  = clr_flag && !full;
    status.sweep_last  = rd_ptr == CNT_W'(MAX_PIXELS - 1);
  end

endmodule

// ===== design/led_frame_power_limit_dither_core.sv =====
// ----------------------------------------------------------------------------
// led_frame_power_limit_dither_core
// frame loader with power-limited brightness and temporally dithered output
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while busy is low (start high); the pixel
// marked frame_end closes the frame. Closing runs the power estimate states
// (product, estimate, request, compare), the bit-serial divider when the
// budget is exceeded, and gain setup; the n stored pixels stream out one per
// cycle on strobe, the first leaving the read and output registers after the
// first read, and busy drops after the drain state that follows the last read.
// A frame with clear_residuals set also sweeps the residual memory entries
// past the frame before busy drops. After reset the whole residual memory is
// swept with busy high; register writes are taken throughout. Results appear
// on strobe for one cycle each and cannot be held off by the receiver.
`include "led_frame_power_limit_dither_core_assert.svh"

module led_frame_power_limit_dither_core import lfpld_pkg::*; #(
  parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        frame_end,
  input  logic [7:0]  brightness,
  input  logic        clear_residuals,
  input  logic        write_en,
  input  logic [1:0]  write_index,
  input  logic [15:0] write_data,
  output logic        strobe,
  output logic [5:0]  pixel_index,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [7:0]  out_blue,
  output logic        last_pixel
);

  cmd_t    cmd;
  status_t status;

  lfpld_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .frame_end (frame_end),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  lfpld_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .frame_end       (frame_end),
    .brightness      (brightness),
    .clear_residuals (clear_residuals),
    .write_en        (write_en),
    .write_index     (write_index),
    .write_data      (write_data),
    .strobe          (strobe),
    .pixel_index     (pixel_index),
    .out_green       (out_green),
    .out_red         (out_red),
    .out_blue        (out_blue),
    .last_pixel      (last_pixel)
  );

  // no word comes out right after a pixel is taken
  `LFPLD_ASSERT_NEXT(a_accept_no_strobe, clk, rst, start && !busy, !strobe)
  // a frame's words stream without gaps
  `LFPLD_ASSERT_NEXT(a_stream_gapless, clk, rst, strobe && !last_pixel, strobe)
  // nothing follows the final word of a frame
  `LFPLD_ASSERT_NEXT(a_last_ends, clk, rst, strobe && last_pixel, !strobe)
  // every word of a frame but the last goes out while busy is still high
  `LFPLD_ASSERT_SAME(a_strobe_busy, clk, rst, strobe && !last_pixel, busy)

endmodule
